// ===== sv/log2_histogram_perf_counter_defines.svh =====
// Assertion macros for the log2 histogram performance counter.
// Included by the module that carries concurrent checks.
`ifndef LOG2_HISTOGRAM_PERF_COUNTER_DEFINES_SVH
`define LOG2_HISTOGRAM_PERF_COUNTER_DEFINES_SVH
`ifndef SYNTHESIS
`define LHPC_ASSERT_NOW(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) else $error(msg);
`define LHPC_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) else $error(msg);
`else
`define LHPC_ASSERT_NOW(lbl, a, c, msg)
`define LHPC_ASSERT_NXT(lbl, a, c, msg)
`endif
`endif

// ===== sv/lhpc_pkg.sv =====
// Types and constants for the log2 histogram performance counter.
// No dependencies.
package lhpc_pkg;
    localparam logic [62:0] MAX63 = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [19:0] ONE_MILLION = 20'd1000000;
    localparam int DIVW = 128;
    localparam int DSRW = 64;

    typedef struct packed {
        logic               req_type;
        logic [62:0]        now_us;
        logic signed [47:0] value;
    } t_in;

    typedef struct packed {
        logic [47:0] sample_count;
        logic [62:0] value_sum;
        logic [62:0] rate_per_sec;
        logic [46:0] average;
        logic [62:0] p99;
        logic [46:0] max_value;
    } t_out;
endpackage

// ===== sv/lhpc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on lhpc_pkg.
module lhpc_div import lhpc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVW-1:0]   i_dividend,
    input  logic [DSRW-1:0]   i_divisor,
    output logic              o_done,
    output logic [DIVW-1:0]   o_quotient
);
    localparam int CW = $clog2(DIVW);

    logic [DSRW-1:0]         r_rem;
    logic [DIVW-1:0]         r_quo;
    logic [DSRW-1:0]         r_dsr;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy, r_done;
    logic [DSRW:0]           t, d;
    logic                    ge;

    always_comb begin
        t  = {r_rem, r_quo[DIVW-1]};
        ge = t >= {1'b0, r_dsr};
        d  = t - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIVW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? d[DSRW-1:0] : t[DSRW-1:0];
            r_quo <= {r_quo[DIVW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ===== sv/log2_histogram_perf_counter.sv =====
// Log2 histogram performance counter: records samples, reports interval statistics.
// A value-mode sample passes through the record state; other samples are taken in idle. A report
// runs the multiplies, the average division and bucket walk (value mode with samples), then the rate division.
// One request at a time; the input stalls while a request is in work or its result waits in S_FIN.
// Synchronous active-low reset clears all statistics; bucket entries use valid bits.
// Depends on lhpc_pkg, lhpc_div and log2_histogram_perf_counter_defines.svh.
`include "log2_histogram_perf_counter_defines.svh"
module log2_histogram_perf_counter import lhpc_pkg::*; #(
    parameter int NUM_BUCKETS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_data,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);
    localparam int IW = $clog2(NUM_BUCKETS);

    localparam logic [3:0] S_IDLE = 4'd0, S_REC = 4'd1, S_M0 = 4'd2, S_M1 = 4'd3,
                           S_M2 = 4'd4, S_DA = 4'd7,
                           S_WA = 4'd8, S_WRD = 4'd9, S_WAC = 4'd10, S_DR = 4'd11,
                           S_WR = 4'd12, S_FIN = 4'd13;

    logic [3:0]  r_state, n_state;
    logic        r_mode;
    logic [47:0] r_cnt;
    logic [62:0] r_sum, r_csum;
    logic [46:0] r_max;
    logic [62:0] r_first, r_last, r_now, r_ivl;
    logic        r_first_v, r_last_v;
    logic [31:0] mem [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] r_bv;
    logic [31:0] r_rd;
    logic        r_rdv;
    logic [IW-1:0] r_idx;
    logic [62:0] r_ssum;
    logic [51:0] r_plo;
    logic [50:0] r_phi;
    logic [82:0] r_prod;
    logic [54:0] r_target;
    logic [46:0] r_avg;
    logic [37:0] r_acc;
    logic        r_found;
    logic [62:0] r_p99, r_rate;
    logic        r_ovalid;
    t_out        r_out;

    logic        acc_in, is_rec, neg;
    logic [46:0] mag, mm1;
    logic [6:0]  bl, bidx;
    logic [IW-1:0] ra;
    logic [31:0] cur, incd;
    logic [31:0] mop;
    logic [51:0] mres;
    logic [63:0] ssum;
    logic        div_start, div_done;
    logic [DIVW-1:0] div_a, quo;
    logic [DSRW-1:0] div_b;
    logic [54:0] tnum, acc100;
    logic [37:0] acc_n;
    logic        hit;
    logic [62:0] bound, start;
    logic        fin_go;

    assign o_in_stall = r_state != S_IDLE;
    assign acc_in     = i_in_valid && !o_in_stall;
    assign is_rec     = !i_in_data.req_type;
    assign neg        = i_in_data.value[47];
    assign mag        = i_in_data.value[46:0];
    assign mm1        = mag - 47'd1;
    assign fin_go     = r_state == S_FIN && (!r_ovalid || !i_out_stall);

    always_comb begin
        bl = '0;
        for (int k = 0; k < 47; k++) begin
            if (mm1[k]) bl = 7'(k + 1);
        end
        if (mag == '0) bidx = '0;
        else if (bl + 7'd1 > 7'(NUM_BUCKETS - 1)) bidx = 7'(NUM_BUCKETS - 1);
        else bidx = bl + 7'd1;
    end

    assign ra   = (r_state == S_IDLE) ? bidx[IW-1:0] : r_idx;
    assign cur  = r_rdv ? r_rd : '0;
    assign incd = (cur == MAX32) ? cur : cur + 32'd1;

    always_ff @(posedge i_clk) begin
        if (r_state == S_REC) mem[r_idx] <= incd;
        r_rd  <= mem[ra];
        r_rdv <= r_bv[ra];
    end

    assign mop    = (r_state == S_M0) ? r_ssum[31:0] : {1'b0, r_ssum[62:32]};
    assign mres   = mop * ONE_MILLION;
    assign ssum   = {1'b0, r_sum} + {17'b0, mag};
    assign tnum   = {7'b0, r_cnt} * 55'd99;
    assign start  = r_last_v ? r_last : r_first;
    assign acc_n  = r_acc + {6'b0, cur};
    assign acc100 = {17'b0, acc_n} * 55'd100;
    assign hit    = acc100 >= r_target;

    always_comb begin
        if (r_idx == '0) bound = '0;
        else if (r_idx == IW'(NUM_BUCKETS - 1)) bound = MAX63;
        else bound = 63'd1 << (r_idx - 1'b1);
    end

    always_comb begin
        div_start = 1'b0;
        div_a     = {45'b0, r_prod};
        div_b     = {1'b0, r_ivl};
        case (r_state)
            S_DA: begin
                div_start = 1'b1;
                div_a = {65'b0, r_sum};
                div_b = {16'b0, r_cnt};
            end
            S_DR: div_start = 1'b1;
            default: ;
        endcase
    end

    lhpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (acc_in) begin
                if (!is_rec) n_state = S_M0;
                else if (!r_mode && !neg) n_state = S_REC;
            end
            S_REC: n_state = S_IDLE;
            S_M0:  n_state = S_M1;
            S_M1:  n_state = S_M2;
            S_M2:  n_state = (!r_mode && r_cnt != '0) ? S_DA : S_DR;
            S_DA:  n_state = S_WA;
            S_WA:  if (div_done) n_state = S_WRD;
            S_WRD: n_state = S_WAC;
            S_WAC: n_state = (r_idx == IW'(NUM_BUCKETS - 1)) ? S_DR : S_WRD;
            S_DR:  n_state = S_WR;
            S_WR:  if (div_done) n_state = S_FIN;
            S_FIN: if (fin_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= 1'b0;
            r_cnt     <= '0;
            r_sum     <= '0;
            r_csum    <= '0;
            r_max     <= '0;
            r_first_v <= 1'b0;
            r_last_v  <= 1'b0;
            r_bv      <= '0;
            r_ovalid  <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_mode <= i_cfg_data;
            if (fin_go) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            if (acc_in && is_rec) begin
                if (!r_first_v) r_first_v <= 1'b1;
                if (r_mode) begin
                    if (!neg && mag != '0) r_csum <= ({1'b0, r_csum} + {17'b0, mag} > {1'b0, MAX63})
                        ? MAX63 : r_csum + {16'b0, mag};
                end else if (!neg) begin
                    if (r_cnt != MAX48) r_cnt <= r_cnt + 48'd1;
                    r_sum <= (ssum > {1'b0, MAX63}) ? MAX63 : ssum[62:0];
                    if (mag > r_max) r_max <= mag;
                end
            end
            if (r_state == S_REC) r_bv[r_idx] <= 1'b1;
            if (r_state == S_M2) r_found <= 1'b0;
            if (r_state == S_WAC && !r_found && hit) r_found <= 1'b1;
            if (fin_go) begin
                r_cnt     <= '0;
                r_sum     <= '0;
                r_csum    <= '0;
                r_max     <= '0;
                r_first_v <= 1'b0;
                r_last_v  <= 1'b1;
                r_bv      <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_idx <= bidx[IW-1:0];
            r_now <= i_in_data.now_us;
            if (is_rec && !r_first_v) r_first <= i_in_data.now_us;
            r_ivl <= ((r_last_v || r_first_v) && i_in_data.now_us > start)
                ? i_in_data.now_us - start : {43'b0, ONE_MILLION};
            r_ssum <= r_mode ? r_csum : r_sum;
            r_p99  <= '0;
            r_avg  <= '0;
        end
        if (r_state == S_M0) begin
            r_plo    <= mres;
            r_target <= tnum;
        end
        if (r_state == S_M1) r_phi <= mres[50:0];
        if (r_state == S_M2) r_prod <= {31'b0, r_plo} + {r_phi, 32'b0};
        if (r_state == S_WA && div_done) begin
            r_avg <= quo[46:0];
            r_idx <= '0;
            r_acc <= '0;
        end
        if (r_state == S_WAC) begin
            r_acc <= acc_n;
            r_idx <= r_idx + 1'b1;
            if (!r_found && hit) r_p99 <= bound;
        end
        if (r_state == S_WR && div_done) r_rate <= (|quo[DIVW-1:63]) ? MAX63 : quo[62:0];
        if (fin_go) begin
            r_last             <= r_now;
            r_out.sample_count <= r_mode ? '0 : r_cnt;
            r_out.value_sum    <= r_ssum;
            r_out.rate_per_sec <= r_rate;
            r_out.average      <= r_avg;
            r_out.p99          <= r_p99;
            r_out.max_value    <= r_mode ? '0 : r_max;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `LHPC_ASSERT_NOW(a_done_wait, div_done, (r_state == S_WA || r_state == S_WR), "divider done outside a wait state")
    `LHPC_ASSERT_NXT(a_found_hold, (r_state == S_WAC && r_found), r_found, "percentile flag dropped during walk")
    `LHPC_ASSERT_NXT(a_fin_clear, fin_go, (r_cnt == '0 && !r_first_v && r_last_v && r_bv == '0), "interval not cleared after report")
endmodule
